// ===== rtl/core/sam_pkg.sv =====
`default_nettype none
package sam_pkg;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int MAX_PIXELS_DEF   = 16777216;
    localparam int MAX_CHANNELS_DEF = 16;
    localparam int ACC_W   = 36;
    localparam int TOTAL_W = 42;
    localparam int TALLY_W = 25;
    localparam int MEAN_W  = 24;
    localparam int ANGLE_STEPS = 20;
    localparam int CW = 28;

    localparam logic [0:0] REG_USE_MASK = 1'd0;
    localparam logic [0:0] REG_MIN_NORM = 1'd1;

    typedef enum logic [3:0] {
        S_IDLE, S_SQA, S_SQB, S_MUL, S_CMP, S_DIV, S_SQS, S_CORD, S_ACC,
        S_MDIV, S_OUT
    } t_state;

    function automatic logic [22:0] atan_q16(input logic [4:0] i);
        case (i)
            5'd0: atan_q16 = 23'd2949120;
            5'd1: atan_q16 = 23'd1740967;
            5'd2: atan_q16 = 23'd919879;
            5'd3: atan_q16 = 23'd466945;
            5'd4: atan_q16 = 23'd234379;
            5'd5: atan_q16 = 23'd117304;
            5'd6: atan_q16 = 23'd58666;
            5'd7: atan_q16 = 23'd29335;
            5'd8: atan_q16 = 23'd14668;
            5'd9: atan_q16 = 23'd7334;
            5'd10: atan_q16 = 23'd3667;
            5'd11: atan_q16 = 23'd1833;
            5'd12: atan_q16 = 23'd917;
            5'd13: atan_q16 = 23'd458;
            5'd14: atan_q16 = 23'd229;
            5'd15: atan_q16 = 23'd115;
            5'd16: atan_q16 = 23'd57;
            5'd17: atan_q16 = 23'd29;
            5'd18: atan_q16 = 23'd14;
            5'd19: atan_q16 = 23'd7;
            default: atan_q16 = 23'd0;
        endcase
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/sam_isqrt.sv =====
`default_nettype none
// Bit-serial integer square root of a 52-bit radicand, one result bit a cycle.
module sam_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [51:0] i_value,
    output logic             o_done,
    output logic [25:0]      o_root
);
    logic [51:0] r_rad, n_rad;
    logic [27:0] r_rem, n_rem;
    logic [25:0] r_root, n_root;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [29:0] w_trial;
    logic [29:0] w_shift;
    logic        w_bit;

    // Restoring square root step: bring down two radicand bits per cycle.
    always_comb begin
        w_shift = {r_rem, r_rad[51:50]};
        w_trial = {2'b00, r_root, 2'b01};
        w_bit = (w_shift >= w_trial);
        n_rad = r_rad; n_rem = r_rem; n_root = r_root; n_cnt = r_cnt; n_busy = r_busy;
        if (i_start) begin
            n_rad = i_value; n_rem = '0; n_root = '0; n_cnt = 5'd0; n_busy = 1'b1;
        end else if (r_busy) begin
            n_rad = {r_rad[49:0], 2'b00};
            if (w_bit) begin
                n_rem = 28'(w_shift - w_trial);
                n_root = {r_root[24:0], 1'b1};
            end else begin
                n_rem = w_shift[27:0];
                n_root = {r_root[24:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'd25) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_rad <= n_rad;
        r_rem <= n_rem;
        r_root <= n_root;
    end

    // The finished root holds even when a new start is taken in the same cycle.
    assign o_done = r_busy && (r_cnt == 5'd25);
    assign o_root = {r_root[24:0], w_bit};
endmodule
`default_nettype wire

// ===== rtl/core/sam_divider.sv =====
`default_nettype none
// Restoring divider, one quotient bit a cycle. Quotient bit count is given.
module sam_divider (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [5:0]  i_bits,
    input  wire logic [52:0] i_rem,
    input  wire logic [52:0] i_num,
    input  wire logic [52:0] i_den,
    output logic             o_done,
    output logic [52:0]      o_quot
);
    logic [52:0] r_rem, n_rem;
    logic [52:0] r_quot, n_quot;
    logic [52:0] r_den;
    logic [5:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [53:0] w_sh;

    // Numerator bits enter at the top of r_quot and shift into the remainder,
    // which starts from i_rem (kept below the divisor).
    always_comb begin
        w_sh = {r_rem, r_quot[52]};
        n_rem = r_rem; n_quot = r_quot; n_cnt = r_cnt; n_busy = r_busy;
        if (i_start) begin
            n_rem = i_rem;
            n_quot = i_num << (6'd53 - i_bits);
            n_cnt = i_bits; n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_den}) begin
                n_rem = 53'(w_sh - {1'b0, r_den});
                n_quot = {r_quot[51:0], 1'b1};
            end else begin
                n_rem = w_sh[52:0];
                n_quot = {r_quot[51:0], 1'b0};
            end
            n_cnt = r_cnt - 6'd1;
            if (r_cnt == 6'd1) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_rem <= n_rem;
        r_quot <= n_quot;
        if (i_start) r_den <= i_den;
    end

    assign o_done = r_busy && (r_cnt == 6'd1);
    assign o_quot = n_quot;
endmodule
`default_nettype wire

// ===== rtl/core/spectral_angle_mapper_mean.sv =====
`default_nettype none
// A channel that is not a pixel's last is summed in S_IDLE, which can then take another channel.
// A pixel's last channel runs through the shared bit-serial square root and divider
// and the CORDIC stage (skipped for a masked-off or low-norm pixel), and no input is
// taken until S_IDLE again; the last pixel adds the mean division and an output state.
// Reset (synchronous, active low) clears the sums, the running total and tally, and the configuration.
module spectral_angle_mapper_mean #(
    parameter int SAMPLE_BITS = sam_pkg::SAMPLE_BITS_DEF,
    parameter int MAX_PIXELS  = sam_pkg::MAX_PIXELS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // sample_a[15:0], sample_b[31:16]
    input  wire logic [1:0]  s_axis_tuser,  // pixel_selected[0], last_pixel[1]
    input  wire logic        s_axis_tlast,  // last_channel
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata   // mean_angle_deg[23:0], pixels_counted[48:24]
);
    import sam_pkg::*;

    localparam logic [63:0] TALLY_CAP = (64'd1 << TALLY_W) - 64'd1;
    localparam logic [TALLY_W-1:0] TALLY_MAX =
        TALLY_W'((64'(MAX_PIXELS) < TALLY_CAP) ? 64'(MAX_PIXELS) : TALLY_CAP);
    localparam logic [15:0] SMASK = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
    localparam logic [ACC_W-1:0] ACC_MAX = '1;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
    localparam logic signed [CW-1:0] RIGHT = CW'(90 * 65536);

    t_state r_state, n_state;
    logic r_use_mask;
    logic [15:0] r_min_norm;
    logic [ACC_W-1:0] r_sa, r_sb, r_dot;
    logic [TOTAL_W-1:0] r_total;
    logic [TALLY_W-1:0] r_tally;
    logic r_lp;
    logic [25:0] r_na, r_nb;
    logic [51:0] r_p;
    logic [16:0] r_c;
    logic signed [CW-1:0] r_x, r_y, r_z;
    logic [4:0] r_i;
    logic [MEAN_W-1:0] r_mean;
    logic [TALLY_W-1:0] r_out_cnt;
    logic r_mul_hi;

    logic w_acc, w_sq_start, w_div_start, w_sq_done, w_div_done;
    logic [51:0] w_sq_val;
    logic [25:0] w_root;
    logic [5:0] w_bits;
    logic [52:0] w_rem, w_num, w_den, w_quot;
    logic [15:0] w_a, w_b;
    logic [32:0] w_cc;

    assign w_a = s_axis_tdata[15:0] & SMASK;
    assign w_b = s_axis_tdata[31:16] & SMASK;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_cc = 33'd1 << 32;

    sam_isqrt u_sqrt (.i_clk, .i_rst_n, .i_start(w_sq_start), .i_value(w_sq_val),
        .o_done(w_sq_done), .o_root(w_root));
    sam_divider u_div (.i_clk, .i_rst_n, .i_start(w_div_start), .i_bits(w_bits),
        .i_rem(w_rem), .i_num(w_num), .i_den(w_den), .o_done(w_div_done),
        .o_quot(w_quot));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_acc && s_axis_tlast) begin
                if (!r_use_mask || s_axis_tuser[0]) n_state = S_SQA;
                else if (s_axis_tuser[1]) n_state = S_MDIV;
            end
            S_SQA: if (w_sq_done) n_state = S_SQB;
            S_SQB: if (w_sq_done) n_state = S_MUL;
            S_MUL: if (r_mul_hi) n_state = S_CMP;
            S_CMP: n_state = (r_p > {20'd0, r_min_norm, 16'd0}) ? S_DIV
                             : (r_lp ? S_MDIV : S_IDLE);
            S_DIV: if (w_div_done || ({1'b0, r_dot, 16'd0} >= {1'b0, r_p}))
                n_state = S_SQS;
            S_SQS: if (w_sq_done) n_state = S_CORD;
            S_CORD: if (r_i == 5'(ANGLE_STEPS - 1)) n_state = S_ACC;
            S_ACC: n_state = r_lp ? S_MDIV : S_IDLE;
            S_MDIV: if (r_tally == '0 || w_div_done) n_state = S_OUT;
            S_OUT: if (m_axis_tready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Unit control.
    always_comb begin
        w_sq_start = 1'b0; w_sq_val = '0;
        w_div_start = 1'b0; w_bits = 6'd16; w_rem = '0; w_num = '0; w_den = '0;
        case (r_state)
            S_IDLE: if (w_acc && s_axis_tlast && (!r_use_mask || s_axis_tuser[0])) begin
                w_sq_start = 1'b1;
                w_sq_val = {sat36(r_sa, 36'(w_a) * 36'(w_a)), 16'd0};
            end
            S_SQA: if (w_sq_done) begin
                w_sq_start = 1'b1; w_sq_val = {r_sb, 16'd0};
            end
            // The cosine divide starts from the scaled dot product as remainder.
            S_CMP: if (r_p > {20'd0, r_min_norm, 16'd0}) begin
                w_div_start = ({1'b0, r_dot, 16'd0} < {1'b0, r_p});
                w_bits = 6'd16; w_rem = {1'b0, r_dot, 16'd0}; w_num = '0;
                w_den = {1'b0, r_p};
            end
            S_DIV: if (w_div_done || ({1'b0, r_dot, 16'd0} >= {1'b0, r_p})) begin
                w_sq_start = 1'b1;
                w_sq_val = {3'd0, 33'(w_cc - 33'(cc_sq(w_div_done ? w_quot[16:0]
                            : 17'd65536))), 16'd0};
            end
            default: ;
        endcase
        if (r_state == S_ACC || (r_state == S_CMP && r_lp &&
            !(r_p > {20'd0, r_min_norm, 16'd0})) ||
            (r_state == S_IDLE && w_acc && s_axis_tlast && r_use_mask &&
             !s_axis_tuser[0] && s_axis_tuser[1])) begin
            w_div_start = (n_tally_f() != '0);
            w_bits = 6'd43;
            w_num = {10'd0, n_total_f()} + 53'(n_tally_f() >> 1);
            w_den = 53'(n_tally_f());
        end
    end

    function automatic logic [ACC_W-1:0] sat36(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
        logic [ACC_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
    endfunction

    function automatic logic [33:0] cc_sq(input logic [16:0] c);
        return 34'(c) * 34'(c);
    endfunction

    // Running total and tally after the pixel being finished, for the mean divide.
    function automatic logic [TOTAL_W-1:0] n_total_f();
        logic [TOTAL_W:0] s;
        s = {1'b0, r_total} + (r_state == S_ACC ? (TOTAL_W+1)'(clamp_z()) : '0);
        return s[TOTAL_W] ? TOTAL_MAX : s[TOTAL_W-1:0];
    endfunction

    function automatic logic [TALLY_W-1:0] n_tally_f();
        if (r_state == S_ACC && r_tally < TALLY_MAX) return r_tally + 1'b1;
        return r_tally;
    endfunction

    function automatic logic [23:0] clamp_z();
        if (r_z < 0) return '0;
        if (r_z > RIGHT) return 24'(RIGHT);
        return 24'(r_z);
    endfunction

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_mask <= 1'b0;
            r_min_norm <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_USE_MASK: r_use_mask <= i_cfg_data[0];
                REG_MIN_NORM: r_min_norm <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Datapath and sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sa <= '0; r_sb <= '0; r_dot <= '0;
            r_total <= '0; r_tally <= '0;
            r_mul_hi <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && w_acc) begin
                r_lp <= s_axis_tuser[1];
                if (s_axis_tlast) begin
                    r_sa <= '0;
                    // A pixel left out by the mask drops its sums at once.
                    if (r_use_mask && !s_axis_tuser[0]) begin
                        r_sb <= '0;
                        r_dot <= '0;
                    end else begin
                        r_sb <= sat36(r_sb, 36'(w_b) * 36'(w_b));
                        r_dot <= sat36(r_dot, 36'(w_a) * 36'(w_b));
                    end
                end else begin
                    r_sa <= sat36(r_sa, 36'(w_a) * 36'(w_a));
                    r_sb <= sat36(r_sb, 36'(w_b) * 36'(w_b));
                    r_dot <= sat36(r_dot, 36'(w_a) * 36'(w_b));
                end
                r_mul_hi <= 1'b0;
            end
            if (r_state == S_SQA && w_sq_done) r_na <= w_root;
            if (r_state == S_SQB && w_sq_done) r_nb <= w_root;
            // Norm product in two 26x13 halves.
            if (r_state == S_MUL) begin
                if (!r_mul_hi) r_p <= 52'(r_na * r_nb[12:0]);
                else r_p <= r_p + (52'(r_na * r_nb[25:13]) << 13);
                r_mul_hi <= 1'b1;
            end
            if (r_state == S_DIV && w_sq_start) r_c <= w_div_done ? w_quot[16:0] : 17'd65536;
            if (r_state == S_SQS && w_sq_done) begin
                r_x <= CW'({r_c, 8'd0}); r_y <= CW'(w_root); r_z <= '0; r_i <= '0;
            end
            // One CORDIC vectoring step per cycle.
            if (r_state == S_CORD) begin
                if (r_y > 0) begin
                    r_x <= r_x + shr(r_y, r_i);
                    r_y <= r_y - shr(r_x, r_i);
                    r_z <= r_z + CW'(atan_q16(r_i));
                end else begin
                    r_x <= r_x - shr(r_y, r_i);
                    r_y <= r_y + shr(r_x, r_i);
                    r_z <= r_z - CW'(atan_q16(r_i));
                end
                r_i <= r_i + 5'd1;
            end
            if (r_state == S_ACC) begin
                r_total <= n_total_f();
                r_tally <= n_tally_f();
                r_dot <= '0; r_sb <= '0;
            end
            // The dot sum is still needed by the cosine step of a passing pixel.
            if (r_state == S_CMP) begin
                r_sb <= '0;
                if (!(r_p > {20'd0, r_min_norm, 16'd0})) r_dot <= '0;
            end
            if (r_state == S_SQB && w_sq_done) r_sb <= '0;
            if (r_state == S_MDIV && n_state == S_OUT) begin
                r_mean <= (r_tally == '0) ? '0 :
                          (w_quot > 53'hFFFFFF ? 24'hFFFFFF : w_quot[23:0]);
                r_out_cnt <= r_tally;
                r_total <= '0; r_tally <= '0;
            end
        end
    end

    function automatic logic signed [CW-1:0] shr(input logic signed [CW-1:0] v,
                                                 input logic [4:0] sh);
        logic signed [CW-1:0] m;
        m = (v < 0) ? -v : v;
        m = m >>> sh;
        return (v < 0) ? -m : m;
    endfunction

    // Outputs.
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
        m_axis_tvalid = (r_state == S_OUT);
        m_axis_tdata = {7'd0, r_out_cnt, r_mean};
    end
endmodule
`default_nettype wire

// ===== rtl/core/sam_checker.sv =====
`default_nettype none
module sam_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata
);
    // Input is never taken while a result is shown.
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(m_axis_tvalid && s_axis_tready)) else $error("ready during output");
    // A zero count gives a zero mean.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[48:24] == 25'd0 |-> m_axis_tdata[23:0] == 24'd0)
        else $error("nonzero mean with empty count");
    // Result stays until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    // Mean never exceeds 90 degrees.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:0] <= 24'd5898240) else $error("mean out of range");
endmodule
bind spectral_angle_mapper_mean sam_checker u_sam_checker (.*);
`default_nettype wire
